### rtl/core/lcd_4bit_parallel_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 4-bit LCD sequencer
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LCD_4BIT_PARALLEL_SEQUENCER_TOP_MACROS_SVH
`define LCD_4BIT_PARALLEL_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCD4_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lcd4 same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCD4_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lcd4 next-cycle check failed");

`endif

### rtl/core/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// LCD sequencer package
// Types, codes and phase decode shared by the 4-bit LCD sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

  localparam int unsigned TickCountWidth = 8;
  localparam int unsigned CfgIndexWidth  = 3;
  localparam int unsigned CfgDataWidth   = 8;

  localparam logic [7:0] PowerOnWaitRst = 8'd40;
  localparam logic [7:0] EnHighRst      = 8'd1;
  localparam logic [7:0] EnLowRst       = 8'd1;
  localparam logic [7:0] CmdSettleRst   = 8'd2;
  localparam logic [7:0] DataSettleRst  = 8'd1;
  localparam logic [7:0] ClearSettleRst = 8'd3;

  localparam logic [7:0] ByteFunctionSet = 8'h28;
  localparam logic [7:0] ByteDisplayOn   = 8'h0C;
  localparam logic [7:0] ByteEntryMode   = 8'h06;
  localparam logic [7:0] ByteClear       = 8'h01;
  localparam logic [3:0] NibWake         = 4'h3;
  localparam logic [3:0] NibFourBit      = 4'h2;
  localparam logic [7:0] AddrLine1       = 8'h80;
  localparam logic [7:0] AddrLine2       = 8'hC0;
  localparam logic [7:0] GapFirst        = 8'd5;
  localparam logic [7:0] GapNext         = 8'd2;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_BYTE   = 3'd1,
    CMD_DATA   = 3'd2,
    CMD_INIT   = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_CURSOR = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_CMD    = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_INIT   = 3'd3,
    KIND_CLEAR  = 3'd4,
    KIND_CURSOR = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_END  = 2'd0,
    PH_WAIT = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } ph_e;

  typedef enum logic [2:0] {
    CFG_POWER_ON_WAIT = 3'd0,
    CFG_EN_HIGH       = 3'd1,
    CFG_EN_LOW        = 3'd2,
    CFG_CMD_SETTLE    = 3'd3,
    CFG_DATA_SETTLE   = 3'd4,
    CFG_CLEAR_SETTLE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] power_on_wait;
    logic [7:0] enable_high_ticks;
    logic [7:0] enable_low_ticks;
    logic [7:0] command_settle;
    logic [7:0] data_settle;
    logic [7:0] clear_settle;
  } cfg_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [5:0] column;
  } req_t;

  typedef struct packed {
    logic       lcd_rs;
    logic       lcd_en;
    logic [3:0] lcd_data;
    logic       busy_res;
    logic       accepted;
  } res_t;

  typedef struct packed {
    ph_e        ph;
    logic [3:0] nib;
    logic [7:0] dur;
  } phase_t;

  function automatic logic [7:0] at_least_one(logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [7:0] init_byte(logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0:    b = ByteFunctionSet;
      2'd1:    b = ByteDisplayOn;
      2'd2:    b = ByteEntryMode;
      default: b = ByteClear;
    endcase
    return b;
  endfunction

  function automatic phase_t byte_phase(logic [2:0] b, logic [7:0] v, logic [7:0] settle,
                                        cfg_t cfg);
    phase_t p;
    p.nib = (b < 3'd2) ? v[7:4] : v[3:0];
    unique case (b)
      3'd0, 3'd2: begin
        p.ph  = PH_HIGH;
        p.dur = at_least_one(cfg.enable_high_ticks);
      end
      3'd1, 3'd3: begin
        p.ph  = PH_LOW;
        p.dur = at_least_one(cfg.enable_low_ticks);
      end
      default: begin
        p.ph  = PH_WAIT;
        p.dur = settle;
      end
    endcase
    return p;
  endfunction

  function automatic phase_t describe(kind_e kind, logic [5:0] step, logic [7:0] pbyte,
                                      logic psel, cfg_t cfg);
    phase_t     p;
    logic [5:0] off;
    logic [1:0] k;
    logic [2:0] b;
    p.ph  = PH_END;
    p.nib = 4'd0;
    p.dur = 8'd0;
    off   = step - 6'd12;
    if (off < 6'd5) begin
      k = 2'd0;
      b = off[2:0];
    end else if (off < 6'd10) begin
      k = 2'd1;
      b = 3'(off - 6'd5);
    end else if (off < 6'd15) begin
      k = 2'd2;
      b = 3'(off - 6'd10);
    end else begin
      k = 2'd3;
      b = 3'(off - 6'd15);
    end
    if (kind == KIND_INIT) begin
      p.nib = (step < 6'd10) ? NibWake : NibFourBit;
      if (step == 6'd0) begin
        p.ph  = PH_WAIT;
        p.dur = cfg.power_on_wait;
      end else if (step == 6'd1 || step == 6'd4 || step == 6'd7 || step == 6'd10) begin
        p.ph  = PH_HIGH;
        p.dur = at_least_one(cfg.enable_high_ticks);
      end else if (step == 6'd2 || step == 6'd5 || step == 6'd8 || step == 6'd11) begin
        p.ph  = PH_LOW;
        p.dur = at_least_one(cfg.enable_low_ticks);
      end else if (step == 6'd3) begin
        p.ph  = PH_WAIT;
        p.dur = GapFirst;
      end else if (step == 6'd6 || step == 6'd9) begin
        p.ph  = PH_WAIT;
        p.dur = GapNext;
      end else if (step < 6'd32) begin
        p = byte_phase(b, init_byte(k), cfg.command_settle, cfg);
      end else if (step == 6'd32) begin
        p.ph  = PH_WAIT;
        p.dur = cfg.clear_settle;
      end
    end else if (kind != KIND_NONE) begin
      if (step < 6'd5) begin
        p = byte_phase(step[2:0], pbyte, psel ? cfg.data_settle : cfg.command_settle, cfg);
      end else if (step == 6'd5 && kind == KIND_CLEAR) begin
        p.ph  = PH_WAIT;
        p.dur = cfg.clear_settle;
      end
    end
    return p;
  endfunction

endpackage

### rtl/core/lcd4_if.sv
// ----------------------------------------------------------------------------
// LCD sequencer channels
// Valid/ready channel interfaces for request items and result items.
// ----------------------------------------------------------------------------
interface lcd4_req_if;
  import lcd4_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lcd4_res_if;
  import lcd4_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/lcd_4bit_parallel_sequencer_top.sv
// ----------------------------------------------------------------------------
// 4-bit parallel LCD sequencer
// Character LCD command, data, clear, cursor and init sequencing timed by tick items.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// req_i     in         command, byte_value, row, column
// res_o     out        lcd_rs, lcd_en, lcd_data, busy_res, accepted
// cfg_*     in         write enable, register index, 8-bit data
//
// One item is taken per cycle unless a stalled result keeps the input register full.
// An input register feeds the sequencer core, whose result goes to an output register.
// Reset clears the sequencer to idle and loads the default timing registers.
// A stalled result holds, and one further item waits in the input register.

module lcd_4bit_parallel_sequencer_top #(
  parameter int unsigned TICK_COUNT_WIDTH = lcd4_pkg::TickCountWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  lcd4_req_if.sink                           req_i,
  lcd4_res_if.source                         res_o,
  input  logic                               cfg_we_i,
  input  logic [lcd4_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [lcd4_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import lcd4_pkg::*;

  logic s1_valid_q, s1_valid_d;
  req_t s1_data_q;
  logic res_valid_q, res_valid_d;
  res_t res_data_q;
  logic res_free;
  logic s1_adv;
  logic in_fire;
  cfg_t cfg;
  res_t step_res;

  lcd4_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lcd4_seq #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_adv),
    .req_i  (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  assign res_free    = !res_valid_q || res_o.ready;
  assign s1_adv      = s1_valid_q && res_free;
  assign req_i.ready = !s1_valid_q || res_free;
  assign in_fire     = req_i.valid && req_i.ready;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign res_valid_d = s1_adv ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= req_i.data;
    end
    if (s1_adv) begin
      res_data_q <= step_res;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_data_q;

endmodule

### rtl/core/lcd4_cfg_regs.sv
// ----------------------------------------------------------------------------
// LCD sequencer configuration registers
// Write-only timing registers, loaded from a plain indexed write port.
// ----------------------------------------------------------------------------
module lcd4_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lcd4_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [lcd4_pkg::CfgDataWidth-1:0]     cfg_data_i,
  output lcd4_pkg::cfg_t                        cfg_o
);
  import lcd4_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POWER_ON_WAIT: cfg_d.power_on_wait     = cfg_data_i;
        CFG_EN_HIGH:       cfg_d.enable_high_ticks = cfg_data_i;
        CFG_EN_LOW:        cfg_d.enable_low_ticks  = cfg_data_i;
        CFG_CMD_SETTLE:    cfg_d.command_settle    = cfg_data_i;
        CFG_DATA_SETTLE:   cfg_d.data_settle       = cfg_data_i;
        CFG_CLEAR_SETTLE:  cfg_d.clear_settle      = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_on_wait     <= PowerOnWaitRst;
      cfg_q.enable_high_ticks <= EnHighRst;
      cfg_q.enable_low_ticks  <= EnLowRst;
      cfg_q.command_settle    <= CmdSettleRst;
      cfg_q.data_settle       <= DataSettleRst;
      cfg_q.clear_settle      <= ClearSettleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/lcd4_seq.sv
// ----------------------------------------------------------------------------
// LCD sequencer core
// Holds the phase state and pin levels and advances them by one item.
// ----------------------------------------------------------------------------
module lcd4_seq #(
  parameter int unsigned TICK_COUNT_WIDTH = lcd4_pkg::TickCountWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  lcd4_pkg::req_t req_i,
  input  lcd4_pkg::cfg_t cfg_i,
  output lcd4_pkg::res_t res_o
);
  import lcd4_pkg::*;

  localparam int unsigned TickMax = (1 << TICK_COUNT_WIDTH) - 1;

  logic [5:0]                  step_q, step_d;
  logic [TICK_COUNT_WIDTH-1:0] wait_q, wait_d;
  logic [7:0]                  pbyte_q, pbyte_d;
  logic                        psel_q, psel_d;
  kind_e                       kind_q, kind_d;
  logic                        pin_sel_q, pin_sel_d;
  logic                        pin_en_q, pin_en_d;
  logic [3:0]                  pin_nib_q, pin_nib_d;
  logic                        acc;

  logic [5:0]                  ch_start;
  kind_e                       ch_kind;
  logic [7:0]                  ch_pbyte;
  logic                        ch_psel;
  logic [5:0]                  ch_step;
  logic [TICK_COUNT_WIDTH-1:0] ch_wait;
  kind_e                       ch_kind_out;
  logic                        ch_sel;
  logic                        ch_en;
  logic [3:0]                  ch_nib;
  logic                        ch_run;
  logic [TICK_COUNT_WIDTH-1:0] wait_dec;
  logic                        busy;

  function automatic logic [TICK_COUNT_WIDTH-1:0] sat(logic [7:0] d);
    if (32'(d) > TickMax) begin
      return TICK_COUNT_WIDTH'(TickMax);
    end
    return TICK_COUNT_WIDTH'(d);
  endfunction

  // Walks through zero-length waits; at most two waits precede a phase that holds.
  always_comb begin
    logic [5:0]                  st;
    logic                        done;
    phase_t                      ph;
    logic [TICK_COUNT_WIDTH-1:0] w;
    st          = ch_start;
    done        = 1'b0;
    ch_step     = 6'd0;
    ch_wait     = '0;
    ch_kind_out = KIND_NONE;
    ch_sel      = pin_sel_q;
    ch_en       = pin_en_q;
    ch_nib      = pin_nib_q;
    for (int i = 0; i < 3; i++) begin
      ph = describe(ch_kind, st, ch_pbyte, ch_psel, cfg_i);
      w  = sat(ph.dur);
      if (!done) begin
        unique case (ph.ph)
          PH_END: begin
            done = 1'b1;
          end
          PH_HIGH: begin
            ch_nib      = ph.nib;
            ch_sel      = ch_psel;
            ch_en       = 1'b1;
            ch_step     = st;
            ch_wait     = w;
            ch_kind_out = ch_kind;
            done        = 1'b1;
          end
          PH_LOW: begin
            ch_en       = 1'b0;
            ch_step     = st;
            ch_wait     = w;
            ch_kind_out = ch_kind;
            done        = 1'b1;
          end
          default: begin
            if (w != '0) begin
              ch_step     = st;
              ch_wait     = w;
              ch_kind_out = ch_kind;
              done        = 1'b1;
            end else begin
              st = st + 6'd1;
            end
          end
        endcase
      end
    end
  end

  assign busy     = (kind_q != KIND_NONE);
  assign wait_dec = (wait_q != '0) ? (wait_q - TICK_COUNT_WIDTH'(1)) : '0;

  always_comb begin
    ch_run   = 1'b0;
    ch_start = step_q + 6'd1;
    ch_kind  = kind_q;
    ch_pbyte = pbyte_q;
    ch_psel  = psel_q;
    acc      = 1'b0;
    step_d   = step_q;
    wait_d   = wait_q;
    kind_d   = kind_q;
    pbyte_d  = pbyte_q;
    psel_d   = psel_q;
    if (fire_i) begin
      if (req_i.command == CMD_TICK) begin
        if (busy) begin
          if (wait_dec == '0) begin
            ch_run = 1'b1;
          end else begin
            wait_d = wait_dec;
          end
        end
      end else if (!busy && req_i.command <= CMD_CURSOR) begin
        acc      = 1'b1;
        ch_run   = 1'b1;
        ch_start = 6'd0;
        ch_kind  = kind_e'(req_i.command);
        ch_psel  = (req_i.command == CMD_DATA);
        unique case (cmd_e'(req_i.command))
          CMD_CLEAR:  ch_pbyte = ByteClear;
          CMD_CURSOR: ch_pbyte = 8'(((req_i.row == 2'd1) ? AddrLine1 : AddrLine2)
                                    + {2'b00, req_i.column} - 8'd1);
          CMD_INIT:   ch_pbyte = 8'd0;
          default:    ch_pbyte = req_i.byte_value;
        endcase
        pbyte_d = ch_pbyte;
        psel_d  = ch_psel;
      end
      if (ch_run) begin
        step_d = ch_step;
        wait_d = ch_wait;
        kind_d = ch_kind_out;
      end
    end
  end

  assign pin_sel_d = ch_run ? ch_sel : pin_sel_q;
  assign pin_en_d  = ch_run ? ch_en  : pin_en_q;
  assign pin_nib_d = ch_run ? ch_nib : pin_nib_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= 6'd0;
      wait_q    <= '0;
      pbyte_q   <= 8'd0;
      psel_q    <= 1'b0;
      kind_q    <= KIND_NONE;
      pin_sel_q <= 1'b0;
      pin_en_q  <= 1'b0;
      pin_nib_q <= 4'd0;
    end else begin
      step_q    <= step_d;
      wait_q    <= wait_d;
      pbyte_q   <= pbyte_d;
      psel_q    <= psel_d;
      kind_q    <= kind_d;
      pin_sel_q <= pin_sel_d;
      pin_en_q  <= pin_en_d;
      pin_nib_q <= pin_nib_d;
    end
  end

  assign res_o.lcd_rs   = pin_sel_d;
  assign res_o.lcd_en   = pin_en_d;
  assign res_o.lcd_data = pin_nib_d;
  assign res_o.busy_res = (kind_d != KIND_NONE);
  assign res_o.accepted = acc;

endmodule

### rtl/core/lcd4_checker.sv
// ----------------------------------------------------------------------------
// LCD sequencer port checker
// Port-level checks on the sequencer's channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcd_4bit_parallel_sequencer_top_macros.svh"

module lcd4_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input lcd4_pkg::res_t res_data_i
);
  import lcd4_pkg::*;

  // Every accepted request starts a sequence that lasts past its own item.
  `LCD4_ASSERT_IMPL(a_accept_busy, clk_i, rst_ni, res_valid_i && res_data_i.accepted, res_data_i.busy_res)

  // The input side only stalls when a result is held back by the sink.
  `LCD4_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !req_ready_i, res_valid_i && !res_ready_i)

  // A result held back by the sink stays valid and unchanged.
  `LCD4_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_data_i))

  // An offered item is always taken while no result is waiting.
  `LCD4_ASSERT_IMPL(a_take_when_empty, clk_i, rst_ni, req_valid_i && !res_valid_i, req_ready_i)

endmodule

bind lcd_4bit_parallel_sequencer_top lcd4_checker u_lcd4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
